[hw/rtl/rhp_pkg.sv]
// Shared types and codes for the RTP header parser.
// Used by rhp_front, rhp_queue and the top level; no dependencies.
package rhp_pkg;

  localparam logic [1:0] KIND_FIXED = 2'd0;
  localparam logic [1:0] KIND_CSRC  = 2'd1;
  localparam logic [1:0] KIND_ELEM  = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_PROFILE   = 3'd1;
  localparam logic [2:0] ST_OVERSIZE  = 3'd2;
  localparam logic [2:0] ST_TRUNC     = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;

  localparam logic [15:0] PROF_ONE_BYTE = 16'hBEDE;
  localparam logic [15:0] PROF_TWO_BYTE = 16'h1000;
  localparam logic [3:0]  ID_RESERVED   = 4'hF;
  localparam logic [15:0] POS_MAX       = 16'hFFFF;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0]  rec_kind;
    logic        marker_bit;
    logic [6:0]  pay_type;
    logic [15:0] seq_num;
    logic [31:0] time_stamp;
    logic [31:0] source_id;
    logic [3:0]  csrc_count;
    logic [2:0]  header_flags;
    logic [7:0]  ext_id;
    logic [15:0] ext_offset;
    logic [7:0]  ext_length;
    logic [2:0]  status;
  } rec_t;

  // Up to two records per byte: a header, CSRC or element record, then the end record.
  typedef struct packed {
    logic a_v;
    logic e_v;
    rec_t a;
    rec_t e;
  } push_t;

endpackage

[hw/rtl/rhp_front.sv]
// Byte parser: tracks packet position and builds the records each byte causes.
// Depends on rhp_pkg.
module rhp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          pkt_byte,
  input  logic                last_byte,
  output rhp_pkg::push_t      push
);

  logic [15:0] pos_r, pos_nxt;
  logic [7:0]  b0_r, b0_nxt, b1_r, b1_nxt, pid_r, pid_nxt;
  logic [15:0] seq_r, seq_nxt, base_r, base_nxt;
  logic [31:0] ts_r, ts_nxt, acc_r, acc_nxt;
  logic [17:0] blk_r, blk_nxt, nxt_r, nxt_nxt;
  logic        two_r, two_nxt, stop_r, stop_nxt;
  logic [2:0]  err_r, err_nxt;

  logic [15:0] p, total, rel, hp3, hp4;
  logic [6:0]  hp;
  logic [18:0] need, hdr_end, elem_end;
  logic [4:0]  len1;
  logic [2:0]  st;
  rhp_pkg::push_t pv;

  always_comb begin
    pos_nxt = pos_r; b0_nxt = b0_r; b1_nxt = b1_r; pid_nxt = pid_r;
    seq_nxt = seq_r; base_nxt = base_r; ts_nxt = ts_r; acc_nxt = acc_r;
    blk_nxt = blk_r; nxt_nxt = nxt_r; two_nxt = two_r; stop_nxt = stop_r;
    err_nxt = err_r;
    pv = '0;
    p = pos_r;
    total = pos_r;
    hp = 7'd12;
    hp3 = '0; hp4 = '0; rel = '0;
    need = '0; hdr_end = '0; elem_end = '0; len1 = '0; st = rhp_pkg::ST_OK;
    if (take) begin
      if (pos_r == rhp_pkg::POS_MAX) begin
        if (err_r == rhp_pkg::ST_OK) err_nxt = rhp_pkg::ST_TOO_LONG;
        total = rhp_pkg::POS_MAX;
      end else begin
        total = pos_r + 16'd1;
        pos_nxt = total;
        acc_nxt = {acc_r[23:0], pkt_byte};
        if (p == 16'd0) b0_nxt = pkt_byte;
        else if (p == 16'd1) b1_nxt = pkt_byte;
        else if (p <= 16'd3) seq_nxt = {seq_r[7:0], pkt_byte};
        else if (p <= 16'd7) ts_nxt = {ts_r[23:0], pkt_byte};
        hp = 7'd12 + {1'b0, b0_nxt[3:0], 2'b00};
        hp3 = {9'd0, hp} + 16'd3;
        hp4 = {9'd0, hp} + 16'd4;
        if (p == 16'd11) begin
          pv.a_v = 1'b1;
          pv.a.rec_kind = rhp_pkg::KIND_FIXED;
          pv.a.marker_bit = b1_nxt[7];
          pv.a.pay_type = b1_nxt[6:0];
          pv.a.seq_num = seq_nxt;
          pv.a.time_stamp = ts_nxt;
          pv.a.source_id = acc_nxt;
          pv.a.csrc_count = b0_nxt[3:0];
        end else if (p >= 16'd12 && p < {9'd0, hp} && p[1:0] == 2'd3) begin
          pv.a_v = 1'b1;
          pv.a.rec_kind = rhp_pkg::KIND_CSRC;
          pv.a.source_id = acc_nxt;
        end
        if (b0_nxt[4] && err_r == rhp_pkg::ST_OK) begin
          if (p == hp3) begin
            if (acc_nxt[31:16] == rhp_pkg::PROF_ONE_BYTE) two_nxt = 1'b0;
            else if (acc_nxt[31:16] == rhp_pkg::PROF_TWO_BYTE) two_nxt = 1'b1;
            else begin
              err_nxt = rhp_pkg::ST_PROFILE;
              stop_nxt = 1'b1;
            end
            base_nxt = hp4;
            blk_nxt = {acc_nxt[15:0], 2'b00};
            nxt_nxt = '0;
          end else if (p >= hp4 && !stop_r) begin
            rel = p - base_r;
            if ({2'b00, rel} < blk_r) begin
              // Element walk: header byte(s) at nxt_r, then data is skipped.
              if ({2'b00, rel} == nxt_r) begin
                hdr_end = {1'b0, nxt_r} + (two_r ? 19'd2 : 19'd1);
                len1 = {1'b0, pkt_byte[3:0]} + 5'd1;
                elem_end = {1'b0, nxt_r} + 19'd1 + {14'd0, len1};
                if (hdr_end >= {1'b0, blk_r}) stop_nxt = 1'b1;
                else if (pkt_byte == 8'd0) nxt_nxt = nxt_r + 18'd1;
                else if (!two_r) begin
                  if (pkt_byte[7:4] == rhp_pkg::ID_RESERVED || pkt_byte[7:4] == 4'd0) begin
                    stop_nxt = 1'b1;
                  end else if (elem_end > {1'b0, blk_r}) begin
                    err_nxt = rhp_pkg::ST_OVERSIZE;
                    stop_nxt = 1'b1;
                  end else begin
                    pv.a_v = 1'b1;
                    pv.a.rec_kind = rhp_pkg::KIND_ELEM;
                    pv.a.ext_id = {4'd0, pkt_byte[7:4]};
                    pv.a.ext_offset = base_r + nxt_r[15:0] + 16'd1;
                    pv.a.ext_length = {3'd0, len1};
                    nxt_nxt = elem_end[17:0];
                  end
                end else pid_nxt = pkt_byte;
              end else if (two_r && {2'b00, rel} == nxt_r + 18'd1) begin
                elem_end = {1'b0, nxt_r} + 19'd2 + {11'd0, pkt_byte};
                if (elem_end > {1'b0, blk_r}) begin
                  err_nxt = rhp_pkg::ST_OVERSIZE;
                  stop_nxt = 1'b1;
                end else begin
                  pv.a_v = 1'b1;
                  pv.a.rec_kind = rhp_pkg::KIND_ELEM;
                  pv.a.ext_id = pid_r;
                  pv.a.ext_offset = base_r + nxt_r[15:0] + 16'd2;
                  pv.a.ext_length = pkt_byte;
                  nxt_nxt = elem_end[17:0];
                end
              end
            end
          end
        end
      end
      pv.a.header_flags = {two_nxt, b0_nxt[5], b0_nxt[4]};
      if (last_byte) begin
        hp = 7'd12 + {1'b0, b0_nxt[3:0], 2'b00};
        st = err_nxt;
        if (st == rhp_pkg::ST_OK) begin
          need = {12'd0, hp};
          if (total >= 16'd12 && b0_nxt[4]) begin
            need = {12'd0, hp} + 19'd4;
            if ({3'd0, total} >= need) need = {3'd0, base_nxt} + {1'b0, blk_nxt};
          end
          if (total < 16'd12 || {3'd0, total} < need) st = rhp_pkg::ST_TRUNC;
        end
        pv.e_v = 1'b1;
        pv.e.rec_kind = rhp_pkg::KIND_END;
        pv.e.header_flags = {two_nxt, b0_nxt[5], b0_nxt[4]};
        pv.e.ext_offset = total;
        pv.e.ext_length = b0_nxt[5] ? pkt_byte : 8'd0;
        pv.e.status = st;
        pos_nxt = '0; b0_nxt = '0; b1_nxt = '0; pid_nxt = '0; seq_nxt = '0;
        base_nxt = '0; ts_nxt = '0; acc_nxt = '0; blk_nxt = '0; nxt_nxt = '0;
        two_nxt = 1'b0; stop_nxt = 1'b0; err_nxt = rhp_pkg::ST_OK;
      end
    end
  end

  assign push = pv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; b0_r <= '0; b1_r <= '0; pid_r <= '0; seq_r <= '0;
      base_r <= '0; ts_r <= '0; acc_r <= '0; blk_r <= '0; nxt_r <= '0;
      two_r <= 1'b0; stop_r <= 1'b0; err_r <= rhp_pkg::ST_OK;
    end else begin
      pos_r <= pos_nxt; b0_r <= b0_nxt; b1_r <= b1_nxt; pid_r <= pid_nxt;
      seq_r <= seq_nxt; base_r <= base_nxt; ts_r <= ts_nxt; acc_r <= acc_nxt;
      blk_r <= blk_nxt; nxt_r <= nxt_nxt; two_r <= two_nxt; stop_r <= stop_nxt;
      err_r <= err_nxt;
    end
  end

endmodule

[hw/rtl/rhp_queue.sv]
// Record queue between the parser and the result channel; two writes, one read a cycle.
// Depends on rhp_pkg.
module rhp_queue #(
  parameter int DEPTH = rhp_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rhp_pkg::push_t push,
  output logic           full,
  output logic           rd_valid,
  input  logic           rd_take,
  output rhp_pkg::rec_t  rd_rec
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rhp_pkg::rec_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp1;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    npush;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] v);
    if (v == AW'(DEPTH - 1)) inc = '0;
    else inc = v + AW'(1);
  endfunction

  assign wp1 = inc(wp_r);
  assign npush = {1'b0, push.a_v} + {1'b0, push.e_v};
  // Room for two records is kept so a byte is never refused mid-flight.
  assign full = cnt_r > CW'(DEPTH - 2);
  assign rd_valid = cnt_r != '0;
  assign rd_rec = mem_r[rp_r];

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (npush == 2'd2) wp_nxt = inc(wp1);
    else if (npush == 2'd1) wp_nxt = wp1;
    if (rd_take) rp_nxt = inc(rp_r);
    cnt_nxt = cnt_r + CW'(npush) - CW'(rd_take);
  end

  always_ff @(posedge clk) begin
    if (push.a_v) mem_r[wp_r] <= push.a;
    if (push.e_v) begin
      if (push.a_v) mem_r[wp1] <= push.e;
      else mem_r[wp_r] <= push.e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue count exceeds depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    rd_take |-> cnt_r != '0) else $error("pop from empty queue");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (npush == 2'd0 && !rd_take) |=> $stable(cnt_r)) else $error("count drifted");

  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    (npush != 2'd0) |-> (cnt_r + CW'(npush) <= CW'(DEPTH)))
    else $error("push overflows queue");

endmodule

[hw/rtl/rtp_header_extension_parser_core.sv]
// RTP header and extension parser, top level.
// Depends on rhp_pkg, rhp_front and rhp_queue.
//
// Usage: packet bytes enter on the in_ channel in wire order, one request per
// byte, with in_last_byte set on the final byte. Results leave on the out_
// channel: a fixed-header record after byte 12, one record per CSRC word,
// one per header extension element, and an end record on the last byte that
// carries status, total length and padding size.
// Each byte is parsed in the cycle it is accepted; its records are registered
// in a QDEPTH-entry queue (four entries by default) and offered in order
// behind any older records. One byte is taken per cycle while in_stall is low;
// a byte that causes two records (the last byte) needs two reads to drain, and
// the queue absorbs that as long as the receiver keeps up.
// in_stall rises when fewer than two queue entries are free, so a stalled
// receiver backs pressure up to the sender; nothing is lost.
// Synchronous active-low reset empties the queue and returns the parser to
// the start of a packet.
module rtp_header_extension_parser_core #(
  parameter int QDEPTH = rhp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pkt_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_rec_kind,
  output logic        out_marker_bit,
  output logic [6:0]  out_pay_type,
  output logic [15:0] out_seq_num,
  output logic [31:0] out_time_stamp,
  output logic [31:0] out_source_id,
  output logic [3:0]  out_csrc_count,
  output logic [2:0]  out_header_flags,
  output logic [7:0]  out_ext_id,
  output logic [15:0] out_ext_offset,
  output logic [7:0]  out_ext_length,
  output logic [2:0]  out_status
);

  rhp_pkg::push_t push;
  rhp_pkg::rec_t  rec;
  logic           full;

  assign in_stall = full;

  rhp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_valid && !full),
    .pkt_byte  (in_pkt_byte),
    .last_byte (in_last_byte),
    .push      (push)
  );

  rhp_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .rd_valid (out_valid),
    .rd_take  (out_valid && !out_stall),
    .rd_rec   (rec)
  );

  assign out_rec_kind     = rec.rec_kind;
  assign out_marker_bit   = rec.marker_bit;
  assign out_pay_type     = rec.pay_type;
  assign out_seq_num      = rec.seq_num;
  assign out_time_stamp   = rec.time_stamp;
  assign out_source_id    = rec.source_id;
  assign out_csrc_count   = rec.csrc_count;
  assign out_header_flags = rec.header_flags;
  assign out_ext_id       = rec.ext_id;
  assign out_ext_offset   = rec.ext_offset;
  assign out_ext_length   = rec.ext_length;
  assign out_status       = rec.status;

endmodule
